### design/bls_pkg.sv
// Shared types and constants for the backtracking line search step block.
`timescale 1ns / 1ps

package bls_pkg;

  localparam logic signed [63:0] Q_ONE   = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] Q_M_ONE = -64'sh0000_0001_0000_0000;

  // Arithmetic unit operations
  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_SQRT  = 3'd4,
    OP_DIV10 = 3'd5
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_OLD_VALUE     = 2'd0,
    REG_INITIAL_SLOPE = 2'd1,
    REG_DECREASE_TOL  = 2'd2,
    REG_MIN_STEP      = 2'd3
  } cfg_reg_t;

  // Result status codes
  localparam logic [2:0] ST_TRY   = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_BACK  = 3'd2;
  localparam logic [2:0] ST_SMALL = 3'd3;
  localparam logic [2:0] ST_TRIES = 3'd4;

endpackage

### design/backtracking_line_search_step.sv
// Top level of the backtracking line search step: sequencer, state and handshakes.
`timescale 1ns / 1ps

// Backtracking line search step (Armijo test, quadratic then cubic fit).
// Channels:
//   cfg   : cfg_valid/cfg_ready, cfg_index selects old_value, initial_slope,
//           decrease_tolerance or min_step; write only while the block is idle.
//   in    : in_valid/in_ready carries trial_value, the objective at the step
//           last reported (1.0 for the first request of a search).
//   out   : out_valid/out_ready carries status and step, one per request.
// Math: all arithmetic runs on one shared unit, and one request is in flight at a time.
//   Multiply, divide, sqrt and div by ten are bit-serial, one bit per cycle.
//   The Armijo test runs first; unless it passes or the step is below min_step,
//   a quadratic proposal follows on the first try and a cubic one on later tries.
// Throughput: in_ready rises once the result is loaded into the output
//   register, so the next request is taken while a result still waits.
// Stall: if out_ready is low, a finished request holds in its final state
//   until the output register frees up.
// Reset: step back to 1.0, try count zero, registers to their reset values
//   (decrease_tolerance about 1e-4).

module backtracking_line_search_step
  import bls_pkg::*;
#(
  parameter int MAX_TRIES = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [63:0] trial_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [32:0]        step
);

  localparam int TW = $clog2(MAX_TRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // micro-steps of the computation
  typedef enum logic [5:0] {
    U_AS, U_AL, U_TH, U_TN,
    U_Q0, U_Q1, U_Q2, U_Q3, U_Q4,
    U_C0, U_C1, U_C2, U_C3, U_C4, U_C5, U_C6, U_C7, U_C8, U_C9,
    U_C10, U_C11, U_C12, U_C13, U_C14, U_C15, U_C16, U_C17, U_C18, U_C19,
    U_C20, U_C21, U_C22, U_C23, U_C24, U_C25, U_C26, U_C27, U_C28, U_C29
  } uop_t;

  // configuration
  logic signed [63:0] old_value;
  logic signed [63:0] initial_slope;
  logic [32:0]        decrease_tolerance;
  logic [32:0]        min_step;

  // search state
  logic [32:0]        current_step;
  logic [32:0]        previous_step;
  logic signed [63:0] previous_value;
  logic [TW-1:0]      try_count;

  // working registers
  state_t             state;
  uop_t               uop;
  logic               issued;
  logic signed [63:0] f;
  logic signed [63:0] thresh, tenth, prop;
  logic signed [63:0] x0, x1, x2, t1, t2, t3, lam2, plam2;
  logic signed [63:0] ca, cb, a3, bb, disc;

  // ALU hookup
  alu_req_t           alu_req;
  alu_op_t            alu_op;
  logic signed [63:0] opa, opb;
  logic               alu_done;
  logic signed [63:0] alu_res;

  logic signed [63:0] lam, plam, tol;
  assign lam  = {31'd0, current_step};
  assign plam = {31'd0, previous_step};
  assign tol  = {31'd0, decrease_tolerance};

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  assign alu_req.start = (state == S_RUN) && !issued;
  assign alu_req.op    = alu_op;

  bls_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (alu_req),
    .a    (opa),
    .b    (opb),
    .done (alu_done),
    .res  (alu_res)
  );

  // operation and operands of each micro-step
  always_comb begin
    alu_op = OP_ADD;
    opa    = '0;
    opb    = '0;
    unique case (uop)
      U_AS:  begin alu_op = OP_MUL;   opa = initial_slope; opb = tol;           end
      U_AL:  begin alu_op = OP_MUL;   opa = x0;            opb = lam;           end
      U_TH:  begin alu_op = OP_ADD;   opa = old_value;     opb = x0;            end
      U_TN:  begin alu_op = OP_DIV10; opa = lam;           opb = '0;            end
      U_Q0:  begin alu_op = OP_SUB;   opa = f;             opb = old_value;     end
      U_Q1:  begin alu_op = OP_SUB;   opa = x0;            opb = initial_slope; end
      U_Q2:  begin alu_op = OP_ADD;   opa = x0;            opb = x0;            end
      U_Q3:  begin alu_op = OP_SUB;   opa = '0;            opb = initial_slope; end
      U_Q4:  begin alu_op = OP_DIV;   opa = x1;            opb = x0;            end
      U_C0:  begin alu_op = OP_SUB;   opa = f;             opb = old_value;     end
      U_C1:  begin alu_op = OP_MUL;   opa = lam;           opb = initial_slope; end
      U_C2:  begin alu_op = OP_SUB;   opa = x0;            opb = x1;            end
      U_C3:  begin alu_op = OP_SUB;   opa = previous_value; opb = old_value;    end
      U_C4:  begin alu_op = OP_MUL;   opa = plam;          opb = initial_slope; end
      U_C5:  begin alu_op = OP_SUB;   opa = x0;            opb = x1;            end
      U_C6:  begin alu_op = OP_SUB;   opa = lam;           opb = plam;          end
      U_C7:  begin alu_op = OP_DIV;   opa = Q_ONE;         opb = x0;            end
      U_C8:  begin alu_op = OP_MUL;   opa = lam;           opb = lam;           end
      U_C9:  begin alu_op = OP_MUL;   opa = plam;          opb = plam;          end
      U_C10: begin alu_op = OP_DIV;   opa = t1;            opb = lam2;          end
      U_C11: begin alu_op = OP_DIV;   opa = t2;            opb = plam2;         end
      U_C12: begin alu_op = OP_SUB;   opa = x0;            opb = x1;            end
      U_C13: begin alu_op = OP_MUL;   opa = t3;            opb = x0;            end
      U_C14: begin alu_op = OP_MUL;   opa = t2;            opb = lam;           end
      U_C15: begin alu_op = OP_DIV;   opa = x0;            opb = plam2;         end
      U_C16: begin alu_op = OP_MUL;   opa = t1;            opb = plam;          end
      U_C17: begin alu_op = OP_DIV;   opa = x1;            opb = lam2;          end
      U_C18: begin alu_op = OP_SUB;   opa = x0;            opb = x1;            end
      U_C19: begin alu_op = OP_MUL;   opa = t3;            opb = x0;            end
      U_C20: begin alu_op = OP_ADD;   opa = ca;            opb = ca;            end
      U_C21: begin alu_op = OP_ADD;   opa = x0;            opb = ca;            end
      U_C22: begin alu_op = OP_MUL;   opa = cb;            opb = cb;            end
      U_C23: begin alu_op = OP_MUL;   opa = a3;            opb = initial_slope; end
      U_C24: begin alu_op = OP_SUB;   opa = bb;            opb = x0;            end
      U_C25: begin alu_op = OP_SQRT;  opa = disc;          opb = '0;            end
      U_C26: begin
        // root takes the sign of a (zero counts as positive)
        if (ca[63]) begin alu_op = OP_SUB; opa = '0; opb = x0; end
        else        begin alu_op = OP_ADD; opa = x0; opb = '0; end
      end
      U_C27: begin alu_op = OP_SUB;   opa = '0;            opb = cb;            end
      U_C28: begin
        alu_op = (disc > bb) ? OP_ADD : OP_SUB;
        opa    = x2;
        opb    = x1;
      end
      U_C29: begin alu_op = OP_DIV;   opa = x0;            opb = a3;            end
      default: begin alu_op = OP_ADD; opa = '0;            opb = '0;            end
    endcase
  end

  // final decision and clamping of the proposal
  logic               pass, too_small, cubic, last_try;
  logic [TW-1:0]      tries;
  logic signed [63:0] half, p1, p2, p3;
  logic [2:0]         fin_status;
  logic [32:0]        fin_step;

  always_comb begin
    pass      = f <= thresh;
    too_small = current_step < min_step;
    cubic     = (try_count != '0);
    tries     = try_count + 1'b1;
    last_try  = tries >= TW'(MAX_TRIES);
    half      = {32'd0, current_step[32:1]};
    p1        = (cubic && prop > half) ? half : prop;
    p2        = (p1 < tenth) ? tenth : p1;
    p3        = (p2 > Q_ONE) ? Q_ONE : p2;
    priority if (pass) begin
      fin_status = cubic ? ST_BACK : ST_FULL;
      fin_step   = current_step;
    end else if (too_small) begin
      fin_status = ST_SMALL;
      fin_step   = current_step;
    end else if (last_try) begin
      fin_status = ST_TRIES;
      fin_step   = current_step;
    end else begin
      fin_status = ST_TRY;
      fin_step   = p3[32:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      uop                <= U_AS;
      issued             <= 1'b0;
      out_valid          <= 1'b0;
      old_value          <= '0;
      initial_slope      <= '0;
      decrease_tolerance <= 33'd429497;
      min_step           <= '0;
      current_step       <= Q_ONE[32:0];
      previous_step      <= '0;
      previous_value     <= Q_M_ONE;
      try_count          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_OLD_VALUE:     old_value          <= cfg_data;
          REG_INITIAL_SLOPE: initial_slope      <= cfg_data;
          REG_DECREASE_TOL:  decrease_tolerance <= cfg_data[32:0];
          REG_MIN_STEP:      min_step           <= cfg_data[32:0];
          default:           min_step           <= min_step;
        endcase
      end

      // drained and not reloaded this cycle
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            f      <= trial_value;
            uop    <= U_AS;
            issued <= 1'b0;
            state  <= S_RUN;
          end
        end
        S_RUN: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (alu_done) begin
            issued <= 1'b0;
            unique case (uop)
              U_AS, U_AL, U_Q0, U_Q1, U_Q2, U_C0, U_C3, U_C6, U_C10, U_C12,
              U_C14, U_C15, U_C18, U_C20, U_C23, U_C25, U_C28: x0 <= alu_res;
              U_C1, U_C4, U_C11, U_C16, U_C17, U_C26, U_Q3:     x1 <= alu_res;
              U_C27: x2     <= alu_res;
              U_TH:  thresh <= alu_res;
              U_C2:  t1     <= alu_res;
              U_C5:  t2     <= alu_res;
              U_C7:  t3     <= alu_res;
              U_C8:  lam2   <= alu_res;
              U_C9:  plam2  <= alu_res;
              U_C13: ca     <= alu_res;
              U_C19: cb     <= alu_res;
              U_C21: a3     <= alu_res;
              U_C22: bb     <= alu_res;
              U_C24: disc   <= alu_res;
              U_TN:  tenth  <= alu_res;
              U_Q4, U_C29: prop <= alu_res;
              default: prop <= prop;
            endcase
            // branch points, else next micro-step
            priority if (uop == U_TN) begin
              if (pass || too_small) state <= S_DONE;
              else                   uop   <= cubic ? U_C0 : U_Q0;
            end else if (uop == U_Q4 || uop == U_C29) begin
              state <= S_DONE;
            end else begin
              uop <= uop_t'(uop + 6'd1);
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status    <= fin_status;
            step      <= fin_step;
            state     <= S_IDLE;
            if (fin_status == ST_TRY) begin
              previous_step  <= current_step;
              previous_value <= f;
              current_step   <= p3[32:0];
              try_count      <= tries;
            end else begin
              // terminal: restart the search
              current_step   <= Q_ONE[32:0];
              previous_step  <= '0;
              previous_value <= Q_M_ONE;
              try_count      <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/bls_alu.sv
// Shared bit-serial Q32.32 arithmetic unit: saturating add/sub, mul, div, sqrt, div by ten.
`timescale 1ns / 1ps

module bls_alu
  import bls_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  alu_req_t           req,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               done,
  output logic signed [63:0] res
);

  localparam logic signed [63:0] S_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S_MIN = 64'sh8000_0000_0000_0000;

  function automatic logic [63:0] mag(input logic [63:0] x);
    mag = x[63] ? (64'd0 - x) : x;
  endfunction

  function automatic logic signed [63:0] sat_signed(input logic [63:0] m, input logic neg);
    if (neg) sat_signed = m[63] ? S_MIN : (64'd0 - m);
    else     sat_signed = m[63] ? S_MAX : m;
  endfunction

  function automatic logic signed [63:0] sat_sum(input logic [64:0] s);
    if (s[64] != s[63]) sat_sum = s[64] ? S_MIN : S_MAX;
    else                sat_sum = s[63:0];
  endfunction

  logic          busy;
  alu_op_t       op_q;
  logic [7:0]    cnt;
  logic [63:0]   acc;
  logic [127:0]  shf;
  logic [63:0]   quo;
  logic [63:0]   opd;
  logic          neg;
  logic          over;

  // iteration temporaries
  logic [64:0] mul_sum;
  logic [64:0] div_r2;
  logic        div_take;
  logic [51:0] sq_rem2;
  logic [51:0] sq_trial;
  logic [51:0] sq_diff;
  logic        sq_take;
  logic [4:0]  d10_r2;
  logic        d10_take;
  logic [63:0] mul_m;

  always_comb begin
    mul_sum  = {1'b0, acc} + (quo[0] ? {1'b0, opd} : 65'd0);
    div_r2   = {acc, shf[127]};
    div_take = acc[63] || (div_r2[63:0] >= opd);
    sq_rem2  = {acc[49:0], shf[127:126]};
    sq_trial = {2'b00, quo[47:0], 2'b01};
    sq_diff  = sq_rem2 - sq_trial;
    sq_take  = sq_rem2 >= sq_trial;
    d10_r2   = {acc[3:0], shf[127]};
    d10_take = d10_r2 >= 5'd10;
    mul_m    = (acc[63:32] != 32'd0) ? 64'hFFFF_FFFF_FFFF_FFFF : {acc[31:0], quo[63:32]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        op_q <= req.op;
        neg  <= a[63] ^ b[63];
        acc  <= '0;
        quo  <= '0;
        over <= 1'b0;
        unique case (req.op)
          OP_ADD: begin
            res  <= sat_sum({a[63], a} + {b[63], b});
            done <= 1'b1;
          end
          OP_SUB: begin
            res  <= sat_sum({a[63], a} - {b[63], b});
            done <= 1'b1;
          end
          OP_MUL: begin
            opd  <= mag(a);
            quo  <= mag(b);
            cnt  <= 8'd64;
            busy <= 1'b1;
          end
          OP_DIV: begin
            if (b == 64'sd0) begin
              res  <= a[63] ? S_MIN : S_MAX;
              done <= 1'b1;
            end else begin
              opd  <= mag(b);
              shf  <= {32'd0, mag(a), 32'd0};
              cnt  <= 8'd128;
              busy <= 1'b1;
            end
          end
          OP_SQRT: begin
            if (a[63] || a == 64'sd0) begin
              res  <= '0;
              done <= 1'b1;
            end else begin
              shf  <= {a, 64'd0};
              cnt  <= 8'd48;
              busy <= 1'b1;
            end
          end
          OP_DIV10: begin
            shf  <= {a[32:0], 95'd0};
            cnt  <= 8'd33;
            busy <= 1'b1;
          end
          default: begin
            res  <= '0;
            done <= 1'b1;
          end
        endcase
      end else if (busy) begin
        if (cnt != 8'd0) begin
          cnt <= cnt - 8'd1;
          unique case (op_q)
            OP_MUL: begin
              acc <= mul_sum[64:1];
              quo <= {mul_sum[0], quo[63:1]};
            end
            OP_DIV: begin
              acc  <= div_take ? (div_r2[63:0] - opd) : div_r2[63:0];
              over <= over | quo[63];
              quo  <= {quo[62:0], div_take};
              shf  <= {shf[126:0], 1'b0};
            end
            OP_SQRT: begin
              acc <= {14'd0, sq_take ? sq_diff[49:0] : sq_rem2[49:0]};
              quo <= {quo[62:0], sq_take};
              shf <= {shf[125:0], 2'b00};
            end
            OP_DIV10: begin
              acc <= {60'd0, d10_take ? (d10_r2[3:0] - 4'd10) : d10_r2[3:0]};
              quo <= {quo[62:0], d10_take};
              shf <= {shf[126:0], 1'b0};
            end
            default: begin
              acc <= acc;
            end
          endcase
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
          unique case (op_q)
            OP_MUL:   res <= sat_signed(mul_m, neg);
            OP_DIV:   res <= sat_signed(over ? 64'hFFFF_FFFF_FFFF_FFFF : quo, neg);
            OP_SQRT:  res <= {16'd0, quo[47:0]};
            OP_DIV10: res <= {31'd0, quo[32:0]};
            default:  res <= '0;
          endcase
        end
      end
    end
  end

endmodule
